FILE: src/lqrac_pkg.sv
// ----------------------------------------------------------------------------
// lqrac_pkg: shared types and constants
// Register codes, sequencer states, per-motor state word and fixed-point
// helpers for the LQR angle controller.
// ----------------------------------------------------------------------------
package lqrac_pkg;

  localparam int COEF_BITS = 24;
  localparam int ACC_W     = 72;

  localparam logic signed [30:0] C_RAD2DEG         = 31'sd961264012;
  localparam logic signed [30:0] C_ALPHA           = 31'sd14260634;
  localparam logic signed [30:0] C_ONE_MINUS_ALPHA = 31'sd2516582;
  localparam logic signed [30:0] C_HALF_DT         = 31'sd16777;

  typedef enum logic [2:0] {
    REG_GAIN_ANGLE       = 3'd0,
    REG_GAIN_RATE        = 3'd1,
    REG_GAIN_INTEGRAL    = 3'd2,
    REG_INTEGRAL_LIMIT   = 3'd3,
    REG_OUTPUT_LIMIT     = 3'd4,
    REG_OUTPUT_RAMP_STEP = 3'd5,
    REG_TARGET_RAMP_STEP = 3'd6,
    REG_REVERSE_MASK     = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_OMEGA,
    ST_FILT_A,
    ST_FILT_B,
    ST_ERR,
    ST_INTEG,
    ST_MUL_A,
    ST_MUL_R,
    ST_MUL_I,
    ST_LIMIT,
    ST_POST
  } seq_state_t;

  typedef struct packed {
    logic signed [31:0] ramped_target;
    logic signed [31:0] filtered_rate;
    logic signed [31:0] integral_sum;
    logic signed [31:0] previous_angle_error;
    logic signed [31:0] previous_output;
  } motor_state_t;

  // shift right by k, rounding half away from zero
  function automatic logic signed [ACC_W-1:0] shr_round(input logic signed [ACC_W-1:0] x,
                                                       input int k);
    logic             neg;
    logic [ACC_W-1:0] mag;
    neg = x[ACC_W-1];
    mag = neg ? ACC_W'(-x) : ACC_W'(x);
    mag = (mag + (ACC_W'(1) << (k - 1))) >> k;
    return neg ? $signed(-mag) : $signed(mag);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
    if (x > $signed(ACC_W'(32'sh7fffffff))) return 32'sh7fffffff;
    if (x < -$signed(ACC_W'(33'sh080000000))) return 32'sh80000000;
    return x[31:0];
  endfunction

endpackage

FILE: src/lqr_angle_controller_with_ramps_core.sv
// ----------------------------------------------------------------------------
// lqr_angle_controller_with_ramps_core: per-motor LQR drive with ramps
// Target ramp, rate filter, deadbands, trapezoidal integral with separation,
// clamp and anti-windup, output deadband with friction, clamp and ramp.
// ----------------------------------------------------------------------------
// Sequence: LOAD, OMEGA, FILT_A, FILT_B, ERR, INTEG, MUL_A, MUL_R, MUL_I, LIMIT
//   and POST (write-back); seven products go through one shared registered
//   multiplier, and no new transaction is taken until the sequencer is idle.
//   A stalled result holds the sequencer in write-back until it drains.
// Per-motor state sits in one RAM (registered read), read at accept, written
//   in the last step, so back-to-back ticks for one motor never overlap.
// Reset: config and control registers return to defaults, all per-motor
//   valid bits clear so every entry reads as zero; no clearing sweep.
module lqr_angle_controller_with_ramps_core #(
  parameter int MOTORS    = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         motor_index,
  input  logic signed [31:0] target_angle,
  input  logic signed [31:0] measured_angle,
  input  logic               angle_present,
  input  logic signed [31:0] measured_rate,
  input  logic               rate_present,
  input  logic               stop,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         motor_index_out,
  output logic signed [31:0] drive
);

  localparam int AW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int AccW = lqrac_pkg::ACC_W;

  // thresholds scaled by 2^FRAC_BITS, rounded
  localparam longint ErrDb   = ((longint'(5) << FRAC_BITS) + 50) / 100;
  localparam longint OutDb   = ((longint'(6) << FRAC_BITS) + 50) / 100;
  localparam longint Fric    = ((longint'(8) << FRAC_BITS) + 50) / 100;
  localparam longint SepThr  = longint'(8) << FRAC_BITS;

  localparam logic signed [33:0] ERR_DB   = 34'(ErrDb);
  localparam logic signed [55:0] OUT_DB   = 56'(OutDb);
  localparam logic signed [55:0] FRICTION = 56'(Fric);
  localparam logic signed [33:0] SEP_THR  = 34'(SepThr);

  // ---------------- configuration registers ----------------
  logic [22:0] gain_angle, gain_rate, gain_integral;
  logic [30:0] integral_limit, output_limit, out_slew_step, target_ramp_step;
  logic [3:0]  reverse_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_angle       <= 23'd2949;
      gain_rate        <= 23'd66;
      gain_integral    <= 23'd164;
      integral_limit   <= 31'd6553600;
      output_limit     <= 31'd655360;
      out_slew_step    <= 31'd22938;
      target_ramp_step <= 31'd39322;
      reverse_mask     <= 4'd0;
    end else if (cfg_write) begin
      case (lqrac_pkg::cfg_reg_t'(cfg_index))
        lqrac_pkg::REG_GAIN_ANGLE:       gain_angle       <= cfg_data[22:0];
        lqrac_pkg::REG_GAIN_RATE:        gain_rate        <= cfg_data[22:0];
        lqrac_pkg::REG_GAIN_INTEGRAL:    gain_integral    <= cfg_data[22:0];
        lqrac_pkg::REG_INTEGRAL_LIMIT:   integral_limit   <= cfg_data;
        lqrac_pkg::REG_OUTPUT_LIMIT:     output_limit     <= cfg_data;
        lqrac_pkg::REG_OUTPUT_RAMP_STEP: out_slew_step    <= cfg_data;
        lqrac_pkg::REG_TARGET_RAMP_STEP: target_ramp_step <= cfg_data;
        lqrac_pkg::REG_REVERSE_MASK:     reverse_mask     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  lqrac_pkg::seq_state_t state, state_next;

  // captured transaction
  logic [1:0]         idx;
  logic               bad;
  logic signed [31:0] tgt_in, theta, rate_in;
  logic               rate_ok, stop_q;

  // state word from RAM, per-motor valid bits
  lqrac_pkg::motor_state_t st, rd_word, wr_word;
  logic [MOTORS-1:0]  vld;
  logic               rd_vld;
  logic               ram_we;

  // datapath registers
  logic signed [31:0] rt_new, fr_new, cand;
  logic signed [37:0] omega;
  logic signed [32:0] th_err, om_err;
  logic signed [55:0] raw;
  logic signed [31:0] raw_lim;
  logic signed [AccW-1:0] acc;
  logic signed [38:0] mul_a;
  logic signed [30:0] mul_b;
  logic signed [69:0] prod;

  wire accept = in_valid && !in_stall;
  wire out_free = !out_valid || !out_stall;

  assign in_stall = (state != lqrac_pkg::ST_IDLE);

  lqrac_ram #(.WIDTH($bits(lqrac_pkg::motor_state_t)), .DEPTH(MOTORS)) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(idx)),
    .wdata (wr_word),
    .raddr (AW'(motor_index)),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lqrac_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lqrac_pkg::ST_IDLE:   if (accept) state_next = lqrac_pkg::ST_LOAD;
      lqrac_pkg::ST_LOAD:   state_next = lqrac_pkg::ST_OMEGA;
      lqrac_pkg::ST_OMEGA:  state_next = lqrac_pkg::ST_FILT_A;
      lqrac_pkg::ST_FILT_A: state_next = lqrac_pkg::ST_FILT_B;
      lqrac_pkg::ST_FILT_B: state_next = lqrac_pkg::ST_ERR;
      lqrac_pkg::ST_ERR:    state_next = lqrac_pkg::ST_INTEG;
      lqrac_pkg::ST_INTEG:  state_next = lqrac_pkg::ST_MUL_A;
      lqrac_pkg::ST_MUL_A:  state_next = lqrac_pkg::ST_MUL_R;
      lqrac_pkg::ST_MUL_R:  state_next = lqrac_pkg::ST_MUL_I;
      lqrac_pkg::ST_MUL_I:  state_next = lqrac_pkg::ST_LIMIT;
      lqrac_pkg::ST_LIMIT:  state_next = lqrac_pkg::ST_POST;
      lqrac_pkg::ST_POST:   if (out_free) state_next = lqrac_pkg::ST_IDLE;
      default:              state_next = lqrac_pkg::ST_IDLE;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      lqrac_pkg::ST_LOAD: begin
        mul_a = 39'(rate_in);
        mul_b = lqrac_pkg::C_RAD2DEG;
      end
      lqrac_pkg::ST_OMEGA: begin
        mul_a = 39'(st.filtered_rate);
        mul_b = lqrac_pkg::C_ALPHA;
      end
      lqrac_pkg::ST_FILT_A: begin
        mul_a = 39'(omega);
        mul_b = lqrac_pkg::C_ONE_MINUS_ALPHA;
      end
      lqrac_pkg::ST_ERR: begin
        mul_a = 39'(th_err) + 39'(st.previous_angle_error);
        mul_b = lqrac_pkg::C_HALF_DT;
      end
      lqrac_pkg::ST_INTEG: begin
        mul_a = 39'(th_err);
        mul_b = $signed({8'd0, gain_angle});
      end
      lqrac_pkg::ST_MUL_A: begin
        mul_a = 39'(om_err);
        mul_b = $signed({8'd0, gain_rate});
      end
      lqrac_pkg::ST_MUL_R: begin
        mul_a = 39'(cand);
        mul_b = $signed({8'd0, gain_integral});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // ---------------- per-step combinational pieces ----------------
  logic signed [31:0] tgt_sel;
  logic signed [32:0] rt_diff, rt_step, rt_clip;
  logic signed [32:0] th_raw;
  logic signed [AccW-1:0] sum_w, rnd;
  logic signed [33:0] inc, cand_w, ilim;
  logic signed [32:0] fr_neg;
  logic signed [55:0] lim_w, raw_db, raw_cl;
  logic signed [32:0] po_diff, po_step, po_clip, set_w, set_fin, neg_set;
  logic               windup, sep;

  always_comb begin
    // target: optional negate (saturating), then ramp
    if (reverse_mask[idx]) begin
      tgt_sel = (tgt_in == 32'sh80000000) ? 32'sh7fffffff : -tgt_in;
    end else begin
      tgt_sel = tgt_in;
    end
    rt_diff = 33'(tgt_sel) - 33'(rd_vld ? rd_word.ramped_target : 32'sd0);
    rt_step = $signed({2'b00, target_ramp_step});
    if (rt_diff > rt_step)       rt_clip = rt_step;
    else if (rt_diff < -rt_step) rt_clip = -rt_step;
    else                         rt_clip = rt_diff;

    th_raw = 33'(rt_new) - 33'(theta);
    fr_neg = -33'(fr_new);

    sum_w = acc + AccW'(prod);

    // integral increment and clamp
    rnd    = lqrac_pkg::shr_round(AccW'(prod), lqrac_pkg::COEF_BITS);
    sep    = ((th_err[32] ? -34'(th_err) : 34'(th_err)) < SEP_THR);
    inc    = rnd[33:0];
    cand_w = 34'(st.integral_sum) + inc;
    ilim   = $signed({3'b000, integral_limit});

    // output stage: deadband, friction and clamp registered in the limit step,
    // ramp toward the clamped value in write-back
    lim_w  = $signed({25'd0, output_limit});
    windup = (raw > lim_w && th_err > 0) || (raw < -lim_w && th_err < 0);
    if ((raw[55] ? -raw : raw) < OUT_DB) raw_db = '0;
    else if (raw > 0)                    raw_db = raw + FRICTION;
    else                                 raw_db = raw - FRICTION;
    if (raw_db > lim_w)       raw_cl = lim_w;
    else if (raw_db < -lim_w) raw_cl = -lim_w;
    else                      raw_cl = raw_db;
    po_diff = 33'(raw_lim) - 33'(st.previous_output);
    po_step = $signed({2'b00, out_slew_step});
    if (po_diff > po_step)       po_clip = po_step;
    else if (po_diff < -po_step) po_clip = -po_step;
    else                         po_clip = po_diff;
    set_w   = 33'(st.previous_output) + po_clip;
    set_fin = stop_q ? 33'sd0 : set_w;
    neg_set = -set_fin;

    wr_word.ramped_target        = rt_new;
    wr_word.filtered_rate        = fr_new;
    wr_word.integral_sum         = stop_q ? 32'sd0 : (windup ? st.integral_sum : cand);
    wr_word.previous_angle_error = lqrac_pkg::sat32(AccW'(th_err));
    wr_word.previous_output      = set_fin[31:0];

    ram_we = (state == lqrac_pkg::ST_POST) && out_free && !bad;
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    case (state)
      lqrac_pkg::ST_IDLE: begin
        if (accept) begin
          idx     <= motor_index;
          bad     <= ({30'd0, motor_index} >= 32'(MOTORS));
          tgt_in  <= target_angle;
          theta   <= angle_present ? measured_angle : 32'sd0;
          rate_in <= measured_rate;
          rate_ok <= rate_present;
          stop_q  <= stop;
          rd_vld  <= vld[AW'(motor_index)];
        end
      end
      lqrac_pkg::ST_LOAD: begin
        st     <= rd_vld ? rd_word : '0;
        rt_new <= 32'(33'(rd_vld ? rd_word.ramped_target : 32'sd0) + rt_clip);
      end
      lqrac_pkg::ST_OMEGA: begin
        omega <= rate_ok ?
                 38'(lqrac_pkg::shr_round(AccW'(prod), lqrac_pkg::COEF_BITS)) : 38'sd0;
      end
      lqrac_pkg::ST_FILT_A: acc <= AccW'(prod);
      lqrac_pkg::ST_FILT_B: begin
        fr_new <= lqrac_pkg::sat32(lqrac_pkg::shr_round(sum_w, lqrac_pkg::COEF_BITS));
        th_err <= ((th_raw[32] ? -34'(th_raw) : 34'(th_raw)) < ERR_DB) ? 33'sd0 : th_raw;
      end
      lqrac_pkg::ST_ERR: begin
        om_err <= ((fr_neg[32] ? -34'(fr_neg) : 34'(fr_neg)) < ERR_DB) ? 33'sd0 : fr_neg;
      end
      lqrac_pkg::ST_INTEG: begin
        if (sep) begin
          if (cand_w > ilim)       cand <= ilim[31:0];
          else if (cand_w < -ilim) cand <= 32'(-ilim);
          else                     cand <= cand_w[31:0];
        end else begin
          cand <= st.integral_sum;
        end
      end
      lqrac_pkg::ST_MUL_A: acc <= AccW'(prod);
      lqrac_pkg::ST_MUL_R: acc <= sum_w;
      lqrac_pkg::ST_MUL_I: raw <= 56'(lqrac_pkg::shr_round(sum_w, FRAC_BITS));
      // clamped value lies within +-output_limit, so 32 bits hold it
      lqrac_pkg::ST_LIMIT: raw_lim <= raw_cl[31:0];
      default: ;
    endcase
  end

  // valid bits: entry reads as zero until first write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ram_we) begin
      vld[AW'(idx)] <= 1'b1;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == lqrac_pkg::ST_POST && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == lqrac_pkg::ST_POST && out_free) begin
      motor_index_out <= idx;
      drive           <= bad ? 32'sd0 : lqrac_pkg::sat32(AccW'(neg_set));
    end
  end

  // ---------------- assertions ----------------
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == lqrac_pkg::ST_LOAD)
    else $error("accepted transaction did not start the state read");

  a_write_in_post: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == lqrac_pkg::ST_POST && !bad)
    else $error("state write outside write-back step");

  a_result_from_post: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == lqrac_pkg::ST_POST)
    else $error("result appeared without a finished transaction");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (state == lqrac_pkg::ST_POST && out_valid && out_stall) |=> state == lqrac_pkg::ST_POST)
    else $error("result register overrun");

endmodule

FILE: src/lqrac_ram.sv
// ----------------------------------------------------------------------------
// lqrac_ram: generic single-write, single-read RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module lqrac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                wdata,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
